// ----- sv/mbe_pkg.sv -----
// shared types, constants and palette table for the mandelbrot escape color block
`default_nettype none

package mbe_pkg;

  localparam int NUM_ITER  = 32;
  localparam int FRAC_BITS = 28;
  localparam int CNT_W     = 6;
  localparam int C_W       = 32;
  localparam int Z_W       = C_W + 1;
  localparam int MUL_W     = FRAC_BITS + 3;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int RGB_W     = 24;
  localparam int PAL_IDX_W = 4;

  typedef struct packed {
    logic                 vld;
    logic                 done;
    logic [CNT_W-1:0]     cnt;
    logic signed [Z_W-1:0] x;
    logic signed [Z_W-1:0] y;
    logic [C_W-1:0]       cr;
    logic [C_W-1:0]       ci;
  } z_t;

  function automatic logic [RGB_W-1:0] palette(input logic [PAL_IDX_W-1:0] idx);
    logic [RGB_W-1:0] w;
    case (idx)
      4'd0:    w = 24'd3939855;
      4'd1:    w = 24'd1640218;
      4'd2:    w = 24'd590127;
      4'd3:    w = 24'd263241;
      4'd4:    w = 24'd1892;
      4'd5:    w = 24'd797834;
      4'd6:    w = 24'd1594033;
      4'd7:    w = 24'd3767761;
      4'd8:    w = 24'd8828389;
      4'd9:    w = 24'd13888760;
      4'd10:   w = 24'd15854015;
      4'd11:   w = 24'd16304479;
      4'd12:   w = 24'd16755200;
      4'd13:   w = 24'd13402112;
      4'd14:   w = 24'd10049280;
      4'd15:   w = 24'd6960131;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- sv/mbe_iter.sv -----
// one escape-time iteration as two pipeline stages: squares, then test and update
`default_nettype none

module mbe_iter import mbe_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [CNT_W-1:0] iter_i,
  input  wire z_t               st_i,
  output z_t                    st_o
);

  localparam logic signed [Z_W-1:0]    Lim   = Z_W'(1) << (FRAC_BITS + 1);
  localparam logic signed [Z_W-1:0]    NegLim = -Lim;
  localparam logic [PROD_W-1:0]        EscTh = PROD_W'(1) << (2 * FRAC_BITS + 2);

  typedef struct packed {
    logic                     vld;
    logic                     done;
    logic                     big;
    logic [CNT_W-1:0]         cnt;
    logic [C_W-1:0]           cr;
    logic [C_W-1:0]           ci;
    logic signed [PROD_W-1:0] xx;
    logic signed [PROD_W-1:0] yy;
    logic signed [PROD_W-1:0] xy;
  } sq_t;

  sq_t s1_d, s1_q;
  z_t  s2_d, s2_q;

  logic signed [MUL_W-1:0]  xm, ym;
  logic [PROD_W-1:0]        sum;
  logic signed [PROD_W-1:0] diff, dsh, psh;
  logic signed [Z_W-1:0]    nx, ny;
  logic                     esc;

  // stage 1: range check and squares
  always_comb begin
    xm          = st_i.x[MUL_W-1:0];
    ym          = st_i.y[MUL_W-1:0];
    s1_d.vld    = st_i.vld;
    s1_d.done   = st_i.done;
    s1_d.big    = (st_i.x > Lim) || (st_i.x < NegLim) || (st_i.y > Lim) || (st_i.y < NegLim);
    s1_d.cnt    = st_i.cnt;
    s1_d.cr     = st_i.cr;
    s1_d.ci     = st_i.ci;
    s1_d.xx     = xm * xm;
    s1_d.yy     = ym * ym;
    s1_d.xy     = xm * ym;
  end

  // stage 2: escape test and z update
  always_comb begin
    sum  = $unsigned(s1_q.xx) + $unsigned(s1_q.yy);
    diff = s1_q.xx - s1_q.yy;
    dsh  = diff >>> FRAC_BITS;
    psh  = s1_q.xy >>> (FRAC_BITS - 1);
    nx   = dsh[Z_W-1:0] + {s1_q.cr[C_W-1], s1_q.cr};
    ny   = psh[Z_W-1:0] + {s1_q.ci[C_W-1], s1_q.ci};
    esc  = s1_q.big || (sum > EscTh);

    s2_d.vld  = s1_q.vld;
    s2_d.done = s1_q.done;
    s2_d.cnt  = s1_q.cnt;
    s2_d.x    = nx;
    s2_d.y    = ny;
    s2_d.cr   = s1_q.cr;
    s2_d.ci   = s1_q.ci;
    if (!s1_q.done) begin
      if (esc) begin
        s2_d.done = 1'b1;
        s2_d.cnt  = iter_i;
      end else if (iter_i == CNT_W'(NUM_ITER)) begin
        s2_d.done = 1'b1;
        s2_d.cnt  = CNT_W'(NUM_ITER + 1);
      end else begin
        s2_d.cnt  = iter_i + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (en_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  assign st_o = s2_q;

endmodule

`default_nettype wire

// ----- sv/mandelbrot_escape_color.sv -----
// mandelbrot escape-time count and palette color, fully unrolled pipeline
//
// input stream: one word per point c, real part in tdata[31:0] and imaginary
// part in tdata[63:32], both signed with 28 fraction bits.
// output stream: one word per point, iteration count (1..33) and the
// red, green and blue bytes of the palette entry chosen by count mod 16.
// each of the 32 iterations is a two-stage unit (squares, then escape test
// and update), with an input and an output register around them, and a word
// passes through all of them before it is valid on the output, in order.
// one point is taken every cycle unless the pipeline is stalled (see below);
// points that escape early ride the rest of the pipeline with their count frozen.
// the whole pipeline advances together: when the receiver holds tready low
// with a word waiting, every stage holds and s_axis_tready drops in the same
// cycle, so nothing is lost or repeated.
// reset clears every valid bit; the pipeline comes up empty and ready.
`default_nettype none

module mandelbrot_escape_color import mbe_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // c_real, c_imag
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // iteration_count, red, green, blue, zero pad
);

  z_t in_d, in_q;
  z_t stage [NUM_ITER+1];

  logic             adv;
  logic             out_vld_d, out_vld_q;
  logic [CNT_W-1:0] out_cnt_d, out_cnt_q;
  logic [RGB_W-1:0] out_rgb_d, out_rgb_q;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // first iteration from z = 0 always passes and leaves z = c
  always_comb begin
    in_d.vld  = s_axis_tvalid;
    in_d.done = 1'b0;
    in_d.cnt  = CNT_W'(1);
    in_d.cr   = s_axis_tdata[C_W-1:0];
    in_d.ci   = s_axis_tdata[2*C_W-1:C_W];
    in_d.x    = {s_axis_tdata[C_W-1], s_axis_tdata[C_W-1:0]};
    in_d.y    = {s_axis_tdata[2*C_W-1], s_axis_tdata[2*C_W-1:C_W]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q      <= '0;
      out_vld_q <= 1'b0;
      out_cnt_q <= '0;
      out_rgb_q <= '0;
    end else if (adv) begin
      in_q      <= in_d;
      out_vld_q <= out_vld_d;
      out_cnt_q <= out_cnt_d;
      out_rgb_q <= out_rgb_d;
    end
  end

  assign stage[0] = in_q;

  for (genvar j = 0; j < NUM_ITER; j++) begin : g_iter
    mbe_iter u_iter (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .iter_i (CNT_W'(j + 1)),
      .st_i   (stage[j]),
      .st_o   (stage[j+1])
    );
  end

  always_comb begin
    out_vld_d = stage[NUM_ITER].vld;
    out_cnt_d = stage[NUM_ITER].cnt;
    out_rgb_d = palette(stage[NUM_ITER].cnt[PAL_IDX_W-1:0]);
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_rgb_q[7:0], out_rgb_q[15:8], out_rgb_q[23:16], out_cnt_q};

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_cnt_q != '0) && (out_cnt_q <= CNT_W'(NUM_ITER + 1)))
    else $error("iteration count out of range");

  a_last_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage[NUM_ITER].vld |-> stage[NUM_ITER].done)
    else $error("word left the last iteration unfinished");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(stage[NUM_ITER]) && $stable(out_cnt_q) && $stable(out_rgb_q))
    else $error("pipeline moved during a stall");

  a_escape_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage[NUM_ITER].vld && stage[NUM_ITER].cnt == CNT_W'(NUM_ITER + 1) && adv)
      |=> (out_rgb_q == palette(PAL_IDX_W'(NUM_ITER + 1))))
    else $error("bounded point got wrong color");

endmodule

`default_nettype wire
